FILE: rtl/core/biou_pkg.sv
// Shared constants and register codes for the box overlap ratio unit.
// No dependencies; compiled first.
package biou_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1
  } cfg_reg_e;

endpackage

FILE: rtl/core/biou_if.sv
// Channel interfaces of the box overlap ratio unit: box pairs in, ratios out,
// configuration writes. Depends on biou_pkg.
interface biou_in_if #(parameter int COORD_BITS = 11);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cur_left;
  logic [COORD_BITS-1:0] cur_top;
  logic [COORD_BITS-1:0] cur_width;
  logic [COORD_BITS-1:0] cur_height;
  logic [COORD_BITS-1:0] old_left;
  logic [COORD_BITS-1:0] old_top;
  logic [COORD_BITS-1:0] old_width;
  logic [COORD_BITS-1:0] old_height;

  modport source (output valid, cur_left, cur_top, cur_width, cur_height,
                  old_left, old_top, old_width, old_height, input ready);
  modport sink (input valid, cur_left, cur_top, cur_width, cur_height,
                old_left, old_top, old_width, old_height, output ready);
endinterface

interface biou_out_if #(parameter int FRAC_BITS = 16);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] overlap_ratio;
  logic               in_band;

  modport source (output valid, overlap_ratio, in_band, input ready);
  modport sink (input valid, overlap_ratio, in_band, output ready);
endinterface

interface biou_cfg_if #(parameter int FRAC_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic [biou_pkg::CFG_IDX_W-1:0] index;
  logic [FRAC_BITS:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/biou_front.sv
// Front end of the overlap ratio pipeline: axis overlaps, areas, union.
// Three registered stages; no package dependencies.
module biou_front #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [2:0]              en,
  input  logic                    in_valid,
  input  logic [COORD_BITS-1:0]   cur_left,
  input  logic [COORD_BITS-1:0]   cur_top,
  input  logic [COORD_BITS-1:0]   cur_width,
  input  logic [COORD_BITS-1:0]   cur_height,
  input  logic [COORD_BITS-1:0]   old_left,
  input  logic [COORD_BITS-1:0]   old_top,
  input  logic [COORD_BITS-1:0]   old_width,
  input  logic [COORD_BITS-1:0]   old_height,
  output logic [2:0]              v,
  output logic [2*COORD_BITS-1:0] inter,
  output logic [2*COORD_BITS:0]   divisor
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 1;
  localparam int AW = 2 * CB;
  localparam int UW = AW + 1;

  function automatic logic [CB-1:0] overlap(input logic [CB-1:0] a0, input logic [CB-1:0] alen,
                                            input logic [CB-1:0] b0, input logic [CB-1:0] blen);
    logic [EW-1:0] a1;
    logic [EW-1:0] b1;
    logic [EW-1:0] lo;
    logic [EW-1:0] hi;
    a1 = EW'(a0) + EW'(alen);
    b1 = EW'(b0) + EW'(blen);
    lo = (a0 > b0) ? EW'(a0) : EW'(b0);
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? CB'(hi - lo) : '0;
  endfunction

  logic [2:0]    v_r;
  logic [CB-1:0] iw_r, ih_r, cw_r, ch_r, ow_r, oh_r;
  logic [AW-1:0] inter1_r, area_c_r, area_o_r;
  logic [AW-1:0] inter2_r;
  logic [UW-1:0] div_r;
  logic [UW-1:0] uni;

  always_comb begin
    uni = UW'(area_c_r) + UW'(area_o_r) - UW'(inter1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      iw_r <= overlap(cur_left, cur_width, old_left, old_width);
      ih_r <= overlap(cur_top, cur_height, old_top, old_height);
      cw_r <= cur_width;
      ch_r <= cur_height;
      ow_r <= old_width;
      oh_r <= old_height;
    end
    if (en[1]) begin
      inter1_r <= AW'(iw_r) * AW'(ih_r);
      area_c_r <= AW'(cw_r) * AW'(ch_r);
      area_o_r <= AW'(ow_r) * AW'(oh_r);
    end
    // empty union: divide zero by one
    if (en[2]) begin
      inter2_r <= inter1_r;
      div_r    <= (uni == '0) ? UW'(1) : uni;
    end
  end

  assign v       = v_r;
  assign inter   = inter2_r;
  assign divisor = div_r;

`ifndef SYNTHESIS
  a_inter_le_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (UW'(inter2_r) <= div_r))
    else $error("intersection exceeds union");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (div_r != '0))
    else $error("zero divisor");
  a_overlap_le_width: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (iw_r <= cw_r && iw_r <= ow_r && ih_r <= ch_r && ih_r <= oh_r))
    else $error("overlap wider than a box");
`endif

endmodule

FILE: rtl/core/biou_div_cell.sv
// One cell of the restoring divider chain: yields one quotient bit per stage.
// No package dependencies.
module biou_div_cell #(
  parameter int UW    = 23,
  parameter int QW    = 17,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [UW:0]   rem_in,
  input  logic [UW-1:0] div_in,
  input  logic [QW-1:0] q_in,
  output logic          v_out,
  output logic [UW:0]   rem_out,
  output logic [UW-1:0] div_out,
  output logic [QW-1:0] q_out
);

  localparam int RW = UW + 1;

  logic          v_r;
  logic [RW-1:0] rem_r;
  logic [UW-1:0] div_r;
  logic [QW-1:0] q_r;
  logic [RW-1:0] trial;
  logic          ge;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;

  always_comb begin
    trial   = FIRST ? rem_in : {rem_in[RW-2:0], 1'b0};
    ge      = trial >= RW'(div_in);
    rem_nxt = ge ? trial - RW'(div_in) : trial;
    q_nxt   = {q_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= div_in;
      q_r   <= q_nxt;
    end
  end

  assign v_out   = v_r;
  assign rem_out = rem_r;
  assign div_out = div_r;
  assign q_out   = q_r;

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (rem_r < RW'(div_r)))
    else $error("partial remainder not below divisor");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !en) |=> ($stable(q_r) && $stable(rem_r)))
    else $error("cell changed while stalled");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (div_r != '0))
    else $error("zero divisor in chain");
`endif

endmodule

FILE: rtl/core/box_iou_unit.sv
// Top level of the box overlap ratio unit: front end, divider chain, band check.
// Depends on biou_pkg, biou_if, biou_front and biou_div_cell.
//
// Takes one box pair per clock and returns the intersection over union as an
// unsigned fixed-point fraction with FRAC_BITS fraction bits (1 << FRAC_BITS
// is 1.0), truncated, plus a flag for the inclusive band [band_low, band_high].
// An empty union gives a ratio of 0. Throughput is one transaction per cycle;
// the path from input to result runs through three front-end stages for
// overlaps, areas and union, then FRAC_BITS + 1 divider cells producing one
// quotient bit each, then the output register. Every stage only holds when the
// stage after it is full and held, so bubbles close up under back-pressure.
// Band registers reset to 0.3 and 0.5 and are written at indexes 0 and 1;
// other indexes are ignored.
module box_iou_unit #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input logic       clk,
  input logic       rst_n,
  biou_in_if.sink   in_ch,
  biou_out_if.source out_ch,
  biou_cfg_if.sink  cfg_ch
);

  import biou_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int AW = 2 * CB;
  localparam int UW = AW + 1;
  localparam int RW = UW + 1;
  localparam int NC = FRAC_BITS + 1;
  localparam int NS = 3 + NC + 1;
  localparam logic [QW-1:0] BAND_LOW_RST  = QW'(((3 << FRAC_BITS) + 5) / 10);
  localparam logic [QW-1:0] BAND_HIGH_RST = QW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] RATIO_ONE     = QW'(1) << FRAC_BITS;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [RW-1:0] rem_c [NC+1];
  logic [UW-1:0] div_c [NC+1];
  logic [QW-1:0] q_c   [NC+1];
  logic [AW-1:0] inter;
  logic [QW-1:0] band_low_r, band_high_r;
  logic          out_valid_r;
  logic [QW-1:0] ratio_r;
  logic          in_band_r;

  assign en[NS-1] = !out_valid_r || out_ch.ready;

  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign v[NS-1]     = out_valid_r;
  assign in_ch.ready = en[0];

  biou_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en[2:0]),
    .in_valid   (in_ch.valid),
    .cur_left   (in_ch.cur_left),
    .cur_top    (in_ch.cur_top),
    .cur_width  (in_ch.cur_width),
    .cur_height (in_ch.cur_height),
    .old_left   (in_ch.old_left),
    .old_top    (in_ch.old_top),
    .old_width  (in_ch.old_width),
    .old_height (in_ch.old_height),
    .v          (v[2:0]),
    .inter      (inter),
    .divisor    (div_c[0])
  );

  assign rem_c[0] = RW'(inter);
  assign q_c[0]   = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    biou_div_cell #(.UW(UW), .QW(QW), .FIRST(k == 0)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[3+k]),
      .v_in    (v[2+k]),
      .rem_in  (rem_c[k]),
      .div_in  (div_c[k]),
      .q_in    (q_c[k]),
      .v_out   (v[3+k]),
      .rem_out (rem_c[k+1]),
      .div_out (div_c[k+1]),
      .q_out   (q_c[k+1])
    );
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= BAND_LOW_RST;
      band_high_r <= BAND_HIGH_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_BAND_LOW:  band_low_r  <= cfg_ch.data;
        REG_BAND_HIGH: band_high_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[NS-1]) begin
      out_valid_r <= v[NS-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      ratio_r   <= q_c[NC];
      in_band_r <= (q_c[NC] >= band_low_r) && (q_c[NC] <= band_high_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.overlap_ratio = ratio_r;
  assign out_ch.in_band       = in_band_r;

`ifndef SYNTHESIS
  a_ratio_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ratio_r <= RATIO_ONE))
    else $error("ratio above one");
  a_band_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (in_band_r == ((ratio_r >= band_low_r) && (ratio_r <= band_high_r))))
    else $error("band flag disagrees with ratio");
  a_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && !v[0]) |-> in_ch.ready)
    else $error("input stalled with a free first stage");
`endif

endmodule
